[hdl/kps_pkg.sv]
// Package for the keypad scanner / PIN entry block: widths, register
// indexes, word structs and the key map. No dependencies.
`default_nettype none
package kps_pkg;

    localparam int ENTRY_DEPTH = 16;
    localparam int IDX_W       = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int LEN_W       = 5;
    localparam int ENTRY_CAP   = (ENTRY_DEPTH < 16) ? ENTRY_DEPTH : 16;
    localparam int CODE_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd4;

    // end causes
    localparam logic [1:0] CAUSE_HASH    = 2'd0;
    localparam logic [1:0] CAUSE_LENGTH  = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
    localparam logic [1:0] CAUSE_OFF     = 2'd3;

    localparam logic [CODE_W-1:0] KEY_HASH = 7'h23;
    localparam logic [CODE_W-1:0] KEY_STAR = 7'h2A;

    localparam logic [3:0] ROWS_IDLE = 4'hF;

    // one job per accepted input word, front to back
    typedef struct packed {
        logic [3:0]        row_drive;
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
        logic              done;
        logic [1:0]        cause;
        logic [LEN_W-1:0]  len;
    } t_job;

    // entry store write port
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [CODE_W-1:0] data;
    } t_wr;

    // 123A / 456B / 789C / *0#D, row by row
    function automatic logic [CODE_W-1:0] key_ascii(input logic [1:0] row,
                                                    input logic [1:0] col);
        logic [CODE_W-1:0] map [16];
        map = '{7'h31, 7'h32, 7'h33, 7'h41,
                7'h34, 7'h35, 7'h36, 7'h42,
                7'h37, 7'h38, 7'h39, 7'h43,
                7'h2A, 7'h30, 7'h23, 7'h44};
        return map[{row, col}];
    endfunction

    // length limit: register value capped at the store depth
    function automatic logic [LEN_W-1:0] len_limit(input logic [LEN_W-1:0] m);
        return (m > LEN_W'(ENTRY_CAP)) ? LEN_W'(ENTRY_CAP) : m;
    endfunction

endpackage
`default_nettype wire

[hdl/kps_if.sv]
// Channel interfaces for the keypad block: input word and result word.
// Depends on kps_pkg.
`default_nettype none
interface kps_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] column_levels;
    logic       start_entry;

    modport source (output valid, output column_levels, output start_entry, input ready);
    modport sink   (input valid, input column_levels, input start_entry, output ready);
endinterface

interface kps_out_if;
    logic                            valid;
    logic                            ready;
    logic [3:0]                      row_drive;
    logic                            key_valid;
    logic [kps_pkg::CODE_W-1:0]      key_code;
    logic                            entry_done;
    logic [1:0]                      end_cause;
    logic [kps_pkg::LEN_W-1:0]       entry_length;
    logic [kps_pkg::CODE_W-1:0]      char_value;
    logic [3:0]                      char_index;
    logic                            last;

    modport source (output valid, output row_drive, output key_valid, output key_code,
                    output entry_done, output end_cause, output entry_length,
                    output char_value, output char_index, output last, input ready);
    modport sink   (input valid, input row_drive, input key_valid, input key_code,
                    input entry_done, input end_cause, input entry_length,
                    input char_value, input char_index, input last, output ready);
endinterface
`default_nettype wire

[hdl/kps_front.sv]
// Front end: config registers, row scan machine and entry session.
// Turns each input word into one job. Depends on kps_pkg, kps_if.
`default_nettype none
module kps_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    kps_in_if.sink                            i_key,
    output logic                              o_push,
    output kps_pkg::t_job                     o_job,
    input  logic                              i_q_full,
    output kps_pkg::t_wr                      o_wr,
    input  logic                              i_run_done
);

    typedef enum logic [3:0] {
        PH_SCAN = 4'b0001,
        PH_DEB  = 4'b0010,
        PH_REL  = 4'b0100,
        PH_GAP  = 4'b1000
    } t_phase;

    logic                        r_enable;
    logic [kps_pkg::LEN_W-1:0]   r_max_len;
    logic [19:0]                 r_timeout;
    logic [7:0]                  r_deb;
    logic [7:0]                  r_gap;

    t_phase                      r_phase, n_phase;
    logic [1:0]                  r_row, n_row;
    logic [7:0]                  r_wait, n_wait;
    logic [1:0]                  r_hrow, n_hrow;
    logic [1:0]                  r_hcol, n_hcol;
    logic                        r_active, n_active;
    logic [kps_pkg::LEN_W-1:0]   r_count, n_count;
    logic [19:0]                 r_elapsed, n_elapsed;
    logic                        r_run_busy;

    logic                        accept;
    logic                        kv;
    logic [kps_pkg::CODE_W-1:0]  code;
    logic [3:0]                  pressed;
    logic [1:0]                  col;
    logic [7:0]                  w_inc;
    logic [3:0]                  drive;
    logic                        done;
    logic [1:0]                  cause;
    logic [kps_pkg::LEN_W-1:0]   len;
    logic [kps_pkg::LEN_W-1:0]   lim;
    logic                        wr_en;

    assign i_key.ready = !i_q_full && !r_run_busy;
    assign accept      = i_key.valid && i_key.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_max_len <= 5'd16;
            r_timeout <= 20'd10000;
            r_deb     <= 8'd50;
            r_gap     <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kps_pkg::CFG_ENABLE:   r_enable  <= i_cfg_data[0];
                kps_pkg::CFG_MAX_LEN:  r_max_len <= i_cfg_data[kps_pkg::LEN_W-1:0];
                kps_pkg::CFG_TIMEOUT:  r_timeout <= i_cfg_data[19:0];
                kps_pkg::CFG_DEBOUNCE: r_deb     <= i_cfg_data[7:0];
                kps_pkg::CFG_GAP:      r_gap     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // scan machine
    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_wait  = r_wait;
        n_hrow  = r_hrow;
        n_hcol  = r_hcol;
        kv      = 1'b0;
        code    = '0;
        pressed = ~i_key.column_levels;
        col     = 2'd0;
        for (int j = 3; j >= 0; j--) begin
            if (pressed[j]) col = 2'(j);
        end
        w_inc = r_wait + 8'd1;
        if (!r_enable) begin
            n_phase = PH_SCAN;
            n_row   = 2'd0;
            n_wait  = 8'd0;
        end else begin
            case (r_phase)
                PH_SCAN: begin
                    if (|pressed) begin
                        n_hrow  = r_row;
                        n_hcol  = col;
                        n_wait  = 8'd0;
                        n_phase = (r_deb != 8'd0) ? PH_DEB : PH_REL;
                    end else begin
                        n_row = r_row + 2'd1;
                    end
                end
                PH_DEB: begin
                    n_wait = w_inc;
                    if (w_inc >= r_deb) n_phase = PH_REL;
                end
                PH_REL: begin
                    if (i_key.column_levels[r_hcol]) begin
                        kv     = 1'b1;
                        code   = kps_pkg::key_ascii(r_hrow, r_hcol);
                        n_wait = 8'd0;
                        if (r_gap != 8'd0) begin
                            n_phase = PH_GAP;
                        end else begin
                            n_phase = PH_SCAN;
                            n_row   = 2'd0;
                        end
                    end
                end
                PH_GAP: begin
                    n_wait = w_inc;
                    if (w_inc >= r_gap) begin
                        n_phase = PH_SCAN;
                        n_row   = 2'd0;
                    end
                end
                default: begin
                    n_phase = PH_SCAN;
                    n_row   = 2'd0;
                end
            endcase
        end
        if (!r_enable || n_phase == PH_GAP) drive = kps_pkg::ROWS_IDLE;
        else if (n_phase == PH_SCAN)        drive = ~(4'b0001 << n_row);
        else                                drive = ~(4'b0001 << n_hrow);
    end

    // entry session
    always_comb begin
        n_active  = r_active || i_key.start_entry;
        n_count   = i_key.start_entry ? '0 : r_count;
        n_elapsed = i_key.start_entry ? '0 : r_elapsed;
        lim       = kps_pkg::len_limit(r_max_len);
        done      = 1'b0;
        cause     = kps_pkg::CAUSE_HASH;
        len       = '0;
        wr_en     = 1'b0;
        if (n_active) begin
            if (!r_enable) begin
                done  = 1'b1;
                cause = kps_pkg::CAUSE_OFF;
            end else if (n_count >= lim) begin
                done  = 1'b1;
                cause = kps_pkg::CAUSE_LENGTH;
                len   = n_count;
            end else if (n_elapsed >= r_timeout) begin
                done  = 1'b1;
                cause = kps_pkg::CAUSE_TIMEOUT;
                len   = n_count;
            end else begin
                if (kv) begin
                    if (code == kps_pkg::KEY_HASH) begin
                        done  = 1'b1;
                        cause = kps_pkg::CAUSE_HASH;
                        len   = n_count;
                    end else if (code == kps_pkg::KEY_STAR) begin
                        if (n_count != '0) n_count = n_count - 5'd1;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = n_count + 5'd1;
                        if (n_count >= lim) begin
                            done  = 1'b1;
                            cause = kps_pkg::CAUSE_LENGTH;
                            len   = n_count;
                        end
                    end
                end
                if (n_elapsed != 20'hFFFFF) n_elapsed = n_elapsed + 20'd1;
            end
            if (done) n_active = 1'b0;
        end
        if (len > kps_pkg::LEN_W'(kps_pkg::ENTRY_CAP)) len = kps_pkg::LEN_W'(kps_pkg::ENTRY_CAP);
    end

    // store address is the count before the increment
    assign o_wr.we   = accept && wr_en;
    assign o_wr.addr = kps_pkg::IDX_W'(n_count - 5'd1);
    assign o_wr.data = code;

    assign o_push          = accept;
    assign o_job.row_drive = drive;
    assign o_job.key_valid = kv;
    assign o_job.key_code  = code;
    assign o_job.done      = done;
    assign o_job.cause     = done ? cause : kps_pkg::CAUSE_HASH;
    assign o_job.len       = len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SCAN;
            r_row      <= 2'd0;
            r_wait     <= 8'd0;
            r_hrow     <= 2'd0;
            r_hcol     <= 2'd0;
            r_active   <= 1'b0;
            r_count    <= '0;
            r_elapsed  <= '0;
            r_run_busy <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_row     <= n_row;
                r_wait    <= n_wait;
                r_hrow    <= n_hrow;
                r_hcol    <= n_hcol;
                r_active  <= n_active;
                r_count   <= n_count;
                r_elapsed <= n_elapsed;
            end
            // hold input until the entry run has left the store
            if (accept && done)  r_run_busy <= 1'b1;
            else if (i_run_done) r_run_busy <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[hdl/kps_queue.sv]
// Two-entry job queue between front and back.
// Depends on kps_pkg.
`default_nettype none
module kps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kps_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output kps_pkg::t_job o_job,
    output logic          o_empty
);

    kps_pkg::t_job                r_slot [kps_pkg::QUEUE_DEPTH];
    logic [kps_pkg::QPTR_W-1:0]   r_wp;
    logic [kps_pkg::QPTR_W-1:0]   r_rp;
    logic [kps_pkg::QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (kps_pkg::QPTR_W+1)'(kps_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/kps_back.sv]
// Back end: entry store memory and result sequencer, one result word per job,
// or one per character of a finished entry with characters. Depends on kps_pkg, kps_if.
`default_nettype none
module kps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kps_pkg::t_wr  i_wr,
    input  logic          i_q_empty,
    input  kps_pkg::t_job i_q_job,
    output logic          o_pop,
    output logic          o_run_done,
    kps_out_if.source     o_res
);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_FETCH = 3'b010,
        BK_SHOW  = 3'b100
    } t_bstate;

    logic [kps_pkg::CODE_W-1:0]  mem [kps_pkg::ENTRY_DEPTH];
    logic [kps_pkg::CODE_W-1:0]  r_rd_data;

    t_bstate                     r_state;
    kps_pkg::t_job               r_job;
    logic [kps_pkg::LEN_W-1:0]   r_k;
    logic [kps_pkg::LEN_W-1:0]   r_n;
    logic                        has_chars;
    logic                        is_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) mem[i_wr.addr] <= i_wr.data;
        r_rd_data <= mem[kps_pkg::IDX_W'(r_k)];
    end

    assign has_chars = r_job.done && (r_job.len != '0);
    assign is_last   = (r_k + 5'd1 == r_n);
    assign o_pop     = (r_state == BK_IDLE) && !i_q_empty;
    assign o_run_done = (r_state == BK_SHOW) && o_res.ready && is_last && r_job.done;

    assign o_res.valid        = (r_state == BK_SHOW);
    assign o_res.row_drive    = r_job.row_drive;
    assign o_res.key_valid    = r_job.key_valid;
    assign o_res.key_code     = r_job.key_code;
    assign o_res.entry_done   = r_job.done;
    assign o_res.end_cause    = r_job.cause;
    assign o_res.entry_length = r_job.len;
    assign o_res.char_value   = has_chars ? r_rd_data : '0;
    assign o_res.char_index   = has_chars ? r_k[3:0] : 4'd0;
    assign o_res.last         = is_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_q_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_k     <= '0;
            r_n     <= 5'd1;
        end else begin
            case (r_state)
                BK_IDLE: begin
                    if (!i_q_empty) begin
                        r_k     <= '0;
                        r_n     <= (i_q_job.done && i_q_job.len != '0) ? i_q_job.len : 5'd1;
                        r_state <= BK_FETCH;
                    end
                end
                BK_FETCH: r_state <= BK_SHOW;
                BK_SHOW: begin
                    if (o_res.ready) begin
                        if (is_last) begin
                            r_state <= BK_IDLE;
                        end else begin
                            r_k     <= r_k + 5'd1;
                            r_state <= BK_FETCH;
                        end
                    end
                end
                default: r_state <= BK_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/keypad_scan_pin_entry.sv]
// Top level of the 4x4 keypad scanner with PIN entry session.
// Depends on kps_pkg, kps_if, kps_front, kps_queue, kps_back.
//
//  channel   dir  handshake              word
//  i_key     in   valid/ready            column_levels[3:0], start_entry
//  o_res     out  valid/ready            row_drive .. last (9 fields)
//  i_cfg_*   in   write enable, no wait  index[2:0], data[19:0]
//
// One input word is one scan tick. The front takes a word whenever the
// queue has room; the back takes a job, then for each result word reads
// the store and then shows the word until it is taken. A plain tick gives
// one result word, a finished entry of L characters max(1,L) words.
// While a finished entry is queued or being sent, the front accepts no
// word; it resumes in the cycle after the last word of the run goes out.
// Reset is synchronous, active low; it clears all control state and
// loads the register defaults. The store itself is not cleared.
`default_nettype none
module keypad_scan_pin_entry (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    kps_in_if.sink                          i_key,
    kps_out_if.source                       o_res
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          run_done;
    kps_pkg::t_job job_in;
    kps_pkg::t_job job_out;
    kps_pkg::t_wr  store_wr;

    // scan and session front end
    kps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key      (i_key),
        .o_push     (push),
        .o_job      (job_in),
        .i_q_full   (q_full),
        .o_wr       (store_wr),
        .i_run_done (run_done)
    );

    // decouples tick processing from result delivery
    kps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (q_empty)
    );

    // store and result sequencer
    kps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (store_wr),
        .i_q_empty  (q_empty),
        .i_q_job    (job_out),
        .o_pop      (pop),
        .o_run_done (run_done),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire

[hdl/kps_checker.sv]
// Port-level checks for keypad_scan_pin_entry, bound to the top level.
// Depends on kps_pkg.
`default_nettype none
module kps_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [3:0]                     i_row_drive,
    input logic                           i_key_valid,
    input logic [kps_pkg::CODE_W-1:0]     i_key_code,
    input logic                           i_entry_done,
    input logic [1:0]                     i_end_cause,
    input logic [kps_pkg::LEN_W-1:0]      i_entry_length,
    input logic [3:0]                     i_char_index,
    input logic                           i_last
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_row_drive) && $stable(i_char_index)
                                && $stable(i_last) && $stable(i_entry_done))
        else $error("result word changed while stalled");

    // at most one row driven low
    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $countones(~i_row_drive) <= 1)
        else $error("more than one row driven");

    // no entry fields without a finished entry, no code without a key
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_entry_done |-> i_end_cause == 2'd0 && i_entry_length == '0
                                     && i_char_index == 4'd0 && i_last
                                     && (i_key_valid || i_key_code == '0))
        else $error("entry fields set without finished entry");

    // run ends exactly at the last character
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_entry_done && i_entry_length != '0
            |-> i_last == (5'(i_char_index) + 5'd1 == i_entry_length))
        else $error("last flag not on final character");

endmodule

bind keypad_scan_pin_entry kps_checker u_kps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_row_drive    (o_res.row_drive),
    .i_key_valid    (o_res.key_valid),
    .i_key_code     (o_res.key_code),
    .i_entry_done   (o_res.entry_done),
    .i_end_cause    (o_res.end_cause),
    .i_entry_length (o_res.entry_length),
    .i_char_index   (o_res.char_index),
    .i_last         (o_res.last)
);
`default_nettype wire
